@@ hw/rtl/rrb_pkg.sv @@
package rrb_pkg;

    localparam int SEQ_W  = 31;
    localparam int LEN_W  = 10;
    localparam int KIND_W = 3;
    localparam int FUNC_W = 2;
    localparam int WIN_W  = 6;

    localparam logic [FUNC_W-1:0] FUNC_DATA = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SYN  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIN  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ACK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REL  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SYN  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIN  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DROP = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture input item
        logic chain_init;  // cursor <= seq + len
        logic chain_step;  // advance cursor through matching entry
        logic chain_done;  // commit cursor to expected
        logic store;       // write item into table if not duplicate and a slot is free
        logic rel_pop;     // release lowest valid entry below expected
        logic out_load;    // load output register
        logic [KIND_W-1:0] out_kind;
        logic out_drop;
        logic out_last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic full;
        logic in_order;
        logic above;
        logic hit;       // cursor matches a valid entry
        logic hit_zero;  // that entry has zero length
        logic rel_any;   // some valid entry below expected
        logic rel_multi; // more than one such entry
    } t_sts;

endpackage

@@ hw/rtl/receive_reorder_buffer.sv @@
// Receive reorder buffer, controller plus datapath.
// Order: SYN reply and drop notice are loaded in the decode state, ACK for out-of-order
//   or stale data in the store state, in-order ACK after the chain, wait, tail and store states.
// Throughput: one item at a time, next accept only after the item's replies and releases
//   are loaded; releases go out one per cycle while the output register is free.
// Reset (i_rst_n low, synchronous): table emptied, expected number set to one.
module receive_reorder_buffer #(
    parameter int CAPACITY = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rrb_pkg::FUNC_W-1:0]    i_func,
    input  logic [rrb_pkg::SEQ_W-1:0]     i_seq_num,
    input  logic [rrb_pkg::LEN_W-1:0]     i_seg_length,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rrb_pkg::KIND_W-1:0]    o_kind,
    output logic [rrb_pkg::SEQ_W-1:0]     o_out_seq,
    output logic [rrb_pkg::LEN_W-1:0]     o_out_length,
    output logic [rrb_pkg::WIN_W-1:0]     o_window,
    output logic                          o_dropped,
    output logic                          o_last
);

    rrb_pkg::t_cmd cmd;
    rrb_pkg::t_sts sts;

    rrb_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    rrb_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_func(i_func), .i_seq_num(i_seq_num), .i_seg_length(i_seg_length),
        .i_cmd(cmd), .o_sts(sts),
        .o_kind(o_kind), .o_out_seq(o_out_seq), .o_out_length(o_out_length),
        .o_window(o_window), .o_dropped(o_dropped), .o_last(o_last)
    );

endmodule

@@ hw/rtl/rrb_datapath.sv @@
module rrb_datapath #(
    parameter int CAPACITY = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [rrb_pkg::FUNC_W-1:0]          i_func,
    input  logic [rrb_pkg::SEQ_W-1:0]           i_seq_num,
    input  logic [rrb_pkg::LEN_W-1:0]           i_seg_length,
    input  rrb_pkg::t_cmd                       i_cmd,
    output rrb_pkg::t_sts                       o_sts,
    output logic [rrb_pkg::KIND_W-1:0]          o_kind,
    output logic [rrb_pkg::SEQ_W-1:0]           o_out_seq,
    output logic [rrb_pkg::LEN_W-1:0]           o_out_length,
    output logic [rrb_pkg::WIN_W-1:0]           o_window,
    output logic                                o_dropped,
    output logic                                o_last
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int TREE  = 1 << IDX_W;

    logic [rrb_pkg::SEQ_W-1:0] r_eseq [CAPACITY];
    logic [rrb_pkg::LEN_W-1:0] r_elen [CAPACITY];
    logic [CAPACITY-1:0]       r_valid;
    logic [CNT_W-1:0]          r_count;
    logic [rrb_pkg::SEQ_W-1:0] r_expected;
    logic [rrb_pkg::SEQ_W-1:0] r_cursor;
    logic [rrb_pkg::FUNC_W-1:0] r_func;
    logic [rrb_pkg::SEQ_W-1:0] r_seq;
    logic [rrb_pkg::LEN_W-1:0] r_len;

    logic [CAPACITY-1:0] hit_vec;
    logic [CAPACITY-1:0] dup_vec;
    logic [CAPACITY-1:0] below_vec;
    logic [IDX_W-1:0]    hit_idx;
    logic [IDX_W-1:0]    free_idx;
    logic                free_any;
    logic [IDX_W-1:0]    min_idx;

    // minimum search tree, node n combines nodes 2n and 2n+1
    logic                      mn_ok  [2*TREE];
    logic [rrb_pkg::SEQ_W-1:0] mn_seq [2*TREE];
    logic [IDX_W-1:0]          mn_idx [2*TREE];

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            hit_vec[i]   = r_valid[i] && (r_eseq[i] == r_cursor);
            dup_vec[i]   = r_valid[i] && (r_eseq[i] == r_seq);
            below_vec[i] = r_valid[i] && (r_eseq[i] < r_expected);
        end
        hit_idx  = '0;
        free_idx = '0;
        free_any = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (hit_vec[i]) hit_idx = IDX_W'(i);
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
                free_any = 1'b1;
            end
        end
    end

    always_comb begin
        mn_ok[0]  = 1'b0;
        mn_seq[0] = '0;
        mn_idx[0] = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            mn_ok[TREE+i]  = below_vec[i];
            mn_seq[TREE+i] = r_eseq[i];
            mn_idx[TREE+i] = IDX_W'(i);
        end
        for (int i = CAPACITY; i < TREE; i++) begin
            mn_ok[TREE+i]  = 1'b0;
            mn_seq[TREE+i] = '0;
            mn_idx[TREE+i] = IDX_W'(i);
        end
        for (int n = TREE - 1; n >= 1; n--) begin
            if (mn_ok[2*n+1] && (!mn_ok[2*n] || mn_seq[2*n+1] < mn_seq[2*n])) begin
                mn_ok[n]  = 1'b1;
                mn_seq[n] = mn_seq[2*n+1];
                mn_idx[n] = mn_idx[2*n+1];
            end else begin
                mn_ok[n]  = mn_ok[2*n];
                mn_seq[n] = mn_seq[2*n];
                mn_idx[n] = mn_idx[2*n];
            end
        end
        min_idx = mn_idx[1];
    end

    always_comb begin
        o_sts.func      = r_func;
        o_sts.full      = (r_count >= CNT_W'(CAPACITY));
        o_sts.in_order  = (r_seq == r_expected);
        o_sts.above     = (r_seq > r_expected);
        o_sts.hit       = |hit_vec;
        o_sts.hit_zero  = (r_elen[hit_idx] == '0);
        o_sts.rel_any   = |below_vec;
        o_sts.rel_multi = |(below_vec & (below_vec - CAPACITY'(1)));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_seq  <= i_seq_num;
            r_len  <= i_seg_length;
        end
        if (i_cmd.chain_init) r_cursor <= r_seq + rrb_pkg::SEQ_W'(r_len);
        else if (i_cmd.chain_step) r_cursor <= r_cursor + rrb_pkg::SEQ_W'(r_elen[hit_idx]);
        if (i_cmd.store && !(|dup_vec) && free_any) begin
            r_eseq[free_idx] <= r_seq;
            r_elen[free_idx] <= r_len;
        end
        if (i_cmd.out_load) begin
            o_kind    <= i_cmd.out_kind;
            o_dropped <= i_cmd.out_drop;
            o_last    <= i_cmd.out_last;
            case (i_cmd.out_kind)
                rrb_pkg::KIND_ACK: begin
                    o_out_seq    <= r_expected;
                    o_out_length <= '0;
                    o_window     <= rrb_pkg::WIN_W'(CAPACITY);
                end
                rrb_pkg::KIND_REL: begin
                    o_out_seq    <= r_eseq[min_idx];
                    o_out_length <= r_elen[min_idx];
                    o_window     <= '0;
                end
                default: begin
                    o_out_seq    <= r_seq;
                    o_out_length <= '0;
                    o_window     <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_count    <= '0;
            r_expected <= rrb_pkg::SEQ_W'(1);
        end else begin
            if (i_cmd.chain_done) r_expected <= r_cursor;
            if (i_cmd.store && !(|dup_vec) && free_any) begin
                r_valid[free_idx] <= 1'b1;
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.rel_pop) begin
                r_valid[min_idx] <= 1'b0;
                if (r_count != '0) r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("count out of step with valid bits");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rel_pop |-> |below_vec)
        else $error("release with no candidate");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.chain_step |-> |hit_vec)
        else $error("chain step with no match");

endmodule

@@ hw/rtl/rrb_ctrl.sv @@
module rrb_ctrl #(
    parameter int CAPACITY = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  rrb_pkg::t_sts i_sts,
    output rrb_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_CHAIN = 3'd2;
    localparam logic [2:0] S_STORE = 3'd3;
    localparam logic [2:0] S_REL   = 3'd4;
    localparam logic [2:0] S_TAIL  = 3'd5;
    localparam logic [2:0] S_WAIT  = 3'd6;

    localparam int STEP_W = $clog2(CAPACITY + 1);

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_steps, n_steps;
    logic              r_drop, n_drop;
    logic              r_ovalid, n_ovalid;

    logic out_free;
    assign out_free = !r_ovalid || i_ready;
    assign o_valid  = r_ovalid;
    assign o_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_steps  = r_steps;
        n_drop   = r_drop;
        n_ovalid = r_ovalid && !i_ready;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                n_drop = 1'b0;
                case (i_sts.func)
                    rrb_pkg::FUNC_DATA: begin
                        if (i_sts.full) begin
                            if (out_free) begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_kind = rrb_pkg::KIND_DROP;
                                o_cmd.out_drop = 1'b1;
                                o_cmd.out_last = !i_sts.rel_any;
                                n_ovalid = 1'b1;
                                n_drop   = 1'b1;
                                n_state  = i_sts.rel_any ? S_REL : S_IDLE;
                            end
                        end else if (i_sts.in_order) begin
                            o_cmd.chain_init = 1'b1;
                            n_steps = '0;
                            n_state = S_CHAIN;
                        end else begin
                            o_cmd.store = i_sts.above;
                            n_state = S_STORE;
                        end
                    end
                    rrb_pkg::FUNC_SYN: begin
                        if (out_free) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_kind = rrb_pkg::KIND_SYN;
                            o_cmd.out_last = 1'b1;
                            n_ovalid = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                    rrb_pkg::FUNC_FIN: begin
                        n_state = S_REL;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_CHAIN: begin
                if (i_sts.hit && r_steps < STEP_W'(CAPACITY - 1) && !i_sts.hit_zero) begin
                    o_cmd.chain_step = 1'b1;
                    n_steps = r_steps + STEP_W'(1);
                end else begin
                    if (i_sts.hit) o_cmd.chain_step = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                o_cmd.chain_done = 1'b1;
                n_state = S_TAIL;
            end
            S_TAIL: begin
                o_cmd.store = 1'b1;
                n_state = S_STORE;
            end
            S_STORE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = rrb_pkg::KIND_ACK;
                    o_cmd.out_last = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_REL: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid = 1'b1;
                    o_cmd.out_drop = r_drop;
                    if (i_sts.rel_any) begin
                        o_cmd.rel_pop  = 1'b1;
                        o_cmd.out_kind = rrb_pkg::KIND_REL;
                        // drop run ends on its final release, no FIN reply
                        if (r_drop && !i_sts.rel_multi) begin
                            o_cmd.out_last = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else begin
                        o_cmd.out_kind = rrb_pkg::KIND_FIN;
                        o_cmd.out_last = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_steps  <= '0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_steps  <= n_steps;
            r_drop   <= n_drop;
            r_ovalid <= n_ovalid;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE)
        else $error("load outside idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |-> !o_cmd.out_load)
        else $error("output overwritten");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.store |-> !o_cmd.rel_pop)
        else $error("store and release together");

endmodule
